/* design/csv_row_offset_indexer_top_defines.svh */
// Assertion macros for the CSV row offset indexer.
// Used by the top level only; assumes clk_i and rst_ni are in scope.
`ifndef CSV_ROW_OFFSET_INDEXER_TOP_DEFINES_SVH
`define CSV_ROW_OFFSET_INDEXER_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define CSVRI_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("csvri assertion failed");

// Next-cycle implication, disabled during reset.
`define CSVRI_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("csvri assertion failed");

`endif

/* design/csvri_pkg.sv */
// Shared types and constants for the CSV row offset indexer.
// No dependencies.
package csvri_pkg;

  localparam int unsigned OFFSET_BITS_DEF = 40;
  localparam int unsigned COUNT_BITS_DEF  = 20;

  localparam int unsigned ROW_OFFSET_W = 40;
  localparam int unsigned FIELD_W      = 20;
  localparam int unsigned STATUS_W     = 2;
  localparam int unsigned ACC_W        = 32;
  localparam int unsigned START_W      = 40;
  localparam int unsigned DATA_W       = 64;
  localparam int unsigned ADDR_W       = 5;

  localparam logic [FIELD_W-1:0] FIELD_MAX = '1;

  // register index, taken from paddr[4:3]
  localparam logic [1:0] REG_EXPECTED = 2'd0;
  localparam logic [1:0] REG_SKIP     = 2'd1;
  localparam logic [1:0] REG_START    = 2'd2;

  localparam logic [STATUS_W-1:0] ST_ACCEPTED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_SKIPPED  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FATAL    = 2'd2;

  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;

  typedef struct packed {
    logic [FIELD_W-1:0] expected;
    logic               skip;
    logic               start_wr;
    logic [START_W-1:0] start_val;
  } cfg_t;

  typedef struct packed {
    logic [ROW_OFFSET_W-1:0] row_offset;
    logic [STATUS_W-1:0]     row_status;
    logic [FIELD_W-1:0]      fields_found;
    logic [ACC_W-1:0]        rows_accepted;
  } res_t;

endpackage

/* design/csvri_cfg_regs.sv */
// APB-style configuration registers of the CSV row offset indexer.
// Depends on csvri_pkg.
module csvri_cfg_regs
  import csvri_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  logic [FIELD_W-1:0] expected_q;
  logic               skip_q;
  logic [START_W-1:0] start_q;
  logic               wr_en;
  logic [1:0]         reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:3];
  assign wr_en   = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_q <= FIELD_W'(1);
      skip_q     <= 1'b1;
      start_q    <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_EXPECTED: expected_q <= pwdata[FIELD_W-1:0];
        REG_SKIP:     skip_q     <= pwdata[0];
        REG_START:    start_q    <= pwdata[START_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_EXPECTED: prdata = DATA_W'(expected_q);
      REG_SKIP:     prdata = DATA_W'(skip_q);
      REG_START:    prdata = DATA_W'(start_q);
      default:      prdata = '0;
    endcase
  end

  // start_offset write also reloads the scanner's position registers
  assign cfg_o.expected  = expected_q;
  assign cfg_o.skip      = skip_q;
  assign cfg_o.start_wr  = wr_en && (reg_idx == REG_START);
  assign cfg_o.start_val = pwdata[START_W-1:0];

endmodule

/* design/csvri_scan.sv */
// Per-byte CSV scanner: quote, CR and field state plus row close logic.
// Depends on csvri_pkg.
module csvri_scan
  import csvri_pkg::*;
#(
  parameter int unsigned OFFSET_BITS = OFFSET_BITS_DEF,
  parameter int unsigned COUNT_BITS  = COUNT_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       accept_i,
  input  logic [7:0] data_byte_i,
  input  logic       end_of_file_i,
  output logic       res_valid_o,
  output res_t       res_o,
  output logic       halted_o
);

  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  logic                   quoted_q, quoted_d;
  logic                   qpend_q, qpend_d;
  logic                   acr_q, acr_d;
  logic                   content_q, content_d;
  logic [COUNT_BITS-1:0]  sep_q, sep_d;
  logic [OFFSET_BITS-1:0] pos_q, pos_d;
  logic [OFFSET_BITS-1:0] start_q, start_d;
  logic [ACC_W-1:0]       acc_q, acc_d;
  logic                   halted_q, halted_d;

  logic                   ended, unq, close;
  logic [OFFSET_BITS-1:0] pos_nx;
  logic [COUNT_BITS-1:0]  fields;
  logic [31:0]            fields_w;
  logic                   match;

  assign pos_nx   = pos_q + OFFSET_BITS'(1);

  always_comb begin
    quoted_d  = quoted_q;
    qpend_d   = qpend_q;
    acr_d     = acr_q;
    content_d = content_q;
    sep_d     = sep_q;
    pos_d     = pos_q;
    start_d   = start_q;
    acc_d     = acc_q;
    halted_d  = halted_q;
    ended     = 1'b0;
    unq       = 1'b1;
    close     = 1'b0;
    fields    = '0;
    fields_w  = '0;
    match     = 1'b0;
    res_valid_o = 1'b0;
    res_o       = '0;

    if (accept_i && !halted_q) begin
      pos_d = pos_nx;

      // LF right after a row-ending CR belongs to that terminator
      if (acr_q) begin
        acr_d = 1'b0;
        if (data_byte_i == CH_LF) begin
          start_d = pos_nx;
          ended   = 1'b1;
          unq     = 1'b0;
        end
      end

      if (unq && quoted_q) begin
        unq = 1'b0;
        if (qpend_q) begin
          qpend_d = 1'b0;
          if (data_byte_i != CH_QUOTE) begin
            quoted_d = 1'b0;
            unq      = 1'b1;
          end
        end else if (data_byte_i == CH_QUOTE) begin
          qpend_d = 1'b1;
        end
      end

      if (unq) begin
        case (data_byte_i)
          CH_COMMA: begin
            if (sep_q != CNT_MAX) sep_d = sep_q + COUNT_BITS'(1);
            content_d = 1'b1;
          end
          CH_QUOTE: begin
            quoted_d  = 1'b1;
            qpend_d   = 1'b0;
            content_d = 1'b1;
          end
          CH_CR, CH_LF: begin
            close = 1'b1;
            ended = 1'b1;
            if (data_byte_i == CH_CR) acr_d = 1'b1;
          end
          CH_SPACE, CH_TAB: ;
          default: content_d = 1'b1;
        endcase
      end

      if (end_of_file_i && !ended) close = 1'b1;

      if (close) begin
        fields   = (sep_d == CNT_MAX) ? sep_d : sep_d + COUNT_BITS'(1);
        fields_w = 32'(fields);
        match    = (fields_w == 32'(cfg_i.expected));
        if (content_d) begin
          res_valid_o      = 1'b1;
          res_o.row_offset = ROW_OFFSET_W'(start_q);
          res_o.fields_found = (fields_w > 32'(FIELD_MAX)) ? FIELD_MAX
                                                          : fields_w[FIELD_W-1:0];
          if (match) begin
            acc_d            = acc_q + ACC_W'(1);
            res_o.row_status = ST_ACCEPTED;
          end else if (cfg_i.skip) begin
            res_o.row_status = ST_SKIPPED;
          end else begin
            res_o.row_status = ST_FATAL;
            halted_d         = 1'b1;
          end
          res_o.rows_accepted = acc_d;
        end
        start_d   = pos_nx;
        sep_d     = '0;
        content_d = 1'b0;
      end

      if (end_of_file_i) begin
        quoted_d  = 1'b0;
        qpend_d   = 1'b0;
        acr_d     = 1'b0;
        content_d = 1'b0;
        sep_d     = '0;
        start_d   = pos_nx;
      end
    end

    if (cfg_i.start_wr) begin
      pos_d   = OFFSET_BITS'(cfg_i.start_val);
      start_d = OFFSET_BITS'(cfg_i.start_val);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quoted_q  <= 1'b0;
      qpend_q   <= 1'b0;
      acr_q     <= 1'b0;
      content_q <= 1'b0;
      sep_q     <= '0;
      pos_q     <= '0;
      start_q   <= '0;
      acc_q     <= '0;
      halted_q  <= 1'b0;
    end else begin
      quoted_q  <= quoted_d;
      qpend_q   <= qpend_d;
      acr_q     <= acr_d;
      content_q <= content_d;
      sep_q     <= sep_d;
      pos_q     <= pos_d;
      start_q   <= start_d;
      acc_q     <= acc_d;
      halted_q  <= halted_d;
    end
  end

  assign halted_o = halted_q;

endmodule

/* design/csvri_out_buf.sv */
// Result register with one skid entry for the CSV row offset indexer.
// Depends on csvri_pkg.
module csvri_out_buf
  import csvri_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic res_valid_i,
  input  res_t res_i,
  input  logic out_stall_i,
  output logic out_valid_o,
  output res_t out_o,
  output logic skid_full_o
);

  logic out_valid_q, skid_valid_q;
  res_t out_q, skid_q;
  logic load_out;

  // output slot is free this cycle if empty or its beat is being taken
  assign load_out = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q  <= skid_valid_q || res_valid_i;
      skid_valid_q <= 1'b0;
    end else if (res_valid_i) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_q <= skid_valid_q ? skid_q : res_i;
    end else if (res_valid_i) begin
      skid_q <= res_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;
  assign skid_full_o = skid_valid_q;

endmodule

/* design/csv_row_offset_indexer_top.sv */
// CSV row offset indexer: takes one byte per cycle from the input stream.
// Throughput: one byte per clock; the input stalls only while the skid entry is full.
// A row's result is registered at the edge that accepts its terminator or EOF byte.
// Reset is asynchronous, active low: scan state clears, positions load start_offset 0,
// registers return to expected_columns 1, skip_wrong_rows 1, start_offset 0.
// Depends on csvri_pkg, csvri_cfg_regs, csvri_scan, csvri_out_buf and the defines header.
`include "csv_row_offset_indexer_top_defines.svh"

module csv_row_offset_indexer_top
  import csvri_pkg::*;
#(
  parameter int unsigned OFFSET_BITS = OFFSET_BITS_DEF,
  parameter int unsigned COUNT_BITS  = COUNT_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [ADDR_W-1:0]       paddr,
  input  logic [DATA_W-1:0]       pwdata,
  output logic [DATA_W-1:0]       prdata,
  output logic                    pready,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [7:0]              data_byte_i,
  input  logic                    end_of_file_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [ROW_OFFSET_W-1:0] row_offset_o,
  output logic [STATUS_W-1:0]     row_status_o,
  output logic [FIELD_W-1:0]      fields_found_o,
  output logic [ACC_W-1:0]        rows_accepted_o
);

  cfg_t cfg;
  res_t res, out;
  logic res_valid, halted, accept, skid_full;

  assign in_stall_o = skid_full;
  assign accept     = in_valid_i && !in_stall_o;

  csvri_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  csvri_scan #(
    .OFFSET_BITS (OFFSET_BITS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_scan (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .accept_i      (accept),
    .data_byte_i   (data_byte_i),
    .end_of_file_i (end_of_file_i),
    .res_valid_o   (res_valid),
    .res_o         (res),
    .halted_o      (halted)
  );

  csvri_out_buf u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_o       (out),
    .skid_full_o (skid_full)
  );

  assign row_offset_o    = out.row_offset;
  assign row_status_o    = out.row_status;
  assign fields_found_o  = out.fields_found;
  assign rows_accepted_o = out.rows_accepted;

  // skid only fills behind an occupied output register
  `CSVRI_ASSERT_IMPL(a_skid_behind_out, skid_full, out_valid_o)
  // a halted scanner never produces a row
  `CSVRI_ASSERT_IMPL(a_halt_silent, halted, !res_valid)
  // a fatal row halts the scanner
  `CSVRI_ASSERT_NEXT(a_fatal_halts, res_valid && (res.row_status == ST_FATAL), halted)

endmodule
